// ===== sv/aes128_pkg.sv =====
// AES-128 encryption package: S-box table, GF(2^8) helpers, sequencer states.
// No dependencies; imported by aes128_round and aes128_block_encrypt.
package aes128_pkg;

  // Default round count and fixed field widths
  localparam int ROUNDS_DEF = 10;
  localparam int KIDX_W     = 5;
  localparam int WORD_W     = 64;
  localparam int BLOCK_W    = 128;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_KEY0,
    ST_ROUND,
    ST_HOLD
  } seq_state_t;

  // Request kinds on in_req_type
  localparam logic REQ_KEY = 1'b0;
  localparam logic REQ_ENC = 1'b1;

  // Forward S-box
  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  // Multiply by x modulo x^8+x^4+x^3+x+1
  function automatic logic [7:0] xtime(input logic [7:0] v);
    logic [7:0] r;
    r = {v[6:0], 1'b0};
    if (v[7]) begin
      r = r ^ 8'h1b;
    end
    return r;
  endfunction

endpackage

// ===== sv/aes128_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module aes128_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 11
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/aes128_round.sv =====
// One AES round: SubBytes, ShiftRows, MixColumns (skipped on the final round),
// AddRoundKey. Combinational; uses aes128_pkg for the S-box and xtime.
module aes128_round import aes128_pkg::*; (
  input  logic [BLOCK_W-1:0] state_in,
  input  logic [BLOCK_W-1:0] round_key,
  input  logic               final_round,
  output logic [BLOCK_W-1:0] state_out
);

  logic [7:0] s [16];
  logic [7:0] t [16];
  logic [7:0] m [16];

  // Byte i sits at row i%4, column i/4; byte 0 in the top bits
  always_comb begin
    for (int i = 0; i < 16; i++) begin
      s[i] = state_in[BLOCK_W-1-8*i -: 8];
    end
  end

  // SubBytes with ShiftRows: row r rotates left by r columns
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[r + 4*c] = SBOX[s[r + 4*((c + r) % 4)]];
      end
    end
  end

  // MixColumns, one column at a time
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      m[4*c]   = xtime(t[4*c]   ^ t[4*c+1]) ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3];
      m[4*c+1] = xtime(t[4*c+1] ^ t[4*c+2]) ^ t[4*c]   ^ t[4*c+2] ^ t[4*c+3];
      m[4*c+2] = xtime(t[4*c+2] ^ t[4*c+3]) ^ t[4*c]   ^ t[4*c+1] ^ t[4*c+3];
      m[4*c+3] = xtime(t[4*c+3] ^ t[4*c])   ^ t[4*c]   ^ t[4*c+1] ^ t[4*c+2];
    end
  end

  // AddRoundKey
  always_comb begin
    for (int i = 0; i < 16; i++) begin
      state_out[BLOCK_W-1-8*i -: 8] = (final_round ? t[i] : m[i])
                                      ^ round_key[BLOCK_W-1-8*i -: 8];
    end
  end

endmodule

// ===== sv/aes128_block_encrypt.sv =====
// AES-128 block encryption with a stored, pre-expanded key schedule.
// Depends on aes128_pkg, aes128_ram (round-key store), aes128_round.
//
//   channel  | direction | ports
//   ---------+-----------+--------------------------------------------------
//   in       | input     | in_valid/in_stall, req_type, key_word_index,
//            |           | key_word, block_hi, block_lo
//   out      | output    | out_valid/out_stall, cipher_hi, cipher_lo
//
// An encrypt word first reads round key 0 for the initial key addition,
// then runs each round through the single shared round unit, paced by
// the registered read of the key store; no new word is taken until the
// block has finished. in_stall is high while a block is being worked.
// The result sits in an output register, so a new word is taken while it
// waits; if the previous result is still stalled at the end of the last
// round the block holds until it leaves. Reset clears the control state
// only; the key store is undefined until written.
module aes128_block_encrypt import aes128_pkg::*; #(
  parameter int ROUNDS = ROUNDS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_req_type,
  input  logic [KIDX_W-1:0]   in_key_word_index,
  input  logic [WORD_W-1:0]   in_key_word,
  input  logic [WORD_W-1:0]   in_block_hi,
  input  logic [WORD_W-1:0]   in_block_lo,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [WORD_W-1:0]   out_cipher_hi,
  output logic [WORD_W-1:0]   out_cipher_lo
);

  localparam int RK_DEPTH = ROUNDS + 1;
  localparam int RA_W     = $clog2(RK_DEPTH);
  localparam logic [KIDX_W-1:0] KEY_WORDS = KIDX_W'(2 * RK_DEPTH);
  localparam logic [RA_W-1:0]   LAST_RND  = RA_W'(ROUNDS);

  seq_state_t         state_r, state_nxt;
  logic [RA_W-1:0]    rnd_r, rnd_nxt;
  logic [BLOCK_W-1:0] blk_r, blk_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [BLOCK_W-1:0] out_r, out_nxt;

  logic               in_acc;
  logic               key_we;
  logic               we_hi, we_lo;
  logic [RA_W-1:0]    waddr;
  logic               rd_en;
  logic [RA_W-1:0]    raddr;
  logic [WORD_W-1:0]  rk_hi, rk_lo;
  logic [BLOCK_W-1:0] round_out;
  logic               out_free;

  // Key store: even words feed bytes 0..7, odd words bytes 8..15
  assign in_acc = in_valid && !in_stall;
  assign key_we = in_acc && (in_req_type == REQ_KEY) && (in_key_word_index < KEY_WORDS);
  assign we_hi  = key_we && !in_key_word_index[0];
  assign we_lo  = key_we && in_key_word_index[0];
  assign waddr  = in_key_word_index[RA_W:1];

  aes128_ram #(.WIDTH(WORD_W), .DEPTH(RK_DEPTH)) u_rk_hi (
    .clk   (clk),
    .we    (we_hi),
    .waddr (waddr),
    .wdata (in_key_word),
    .re    (rd_en),
    .raddr (raddr),
    .rdata (rk_hi)
  );

  aes128_ram #(.WIDTH(WORD_W), .DEPTH(RK_DEPTH)) u_rk_lo (
    .clk   (clk),
    .we    (we_lo),
    .waddr (waddr),
    .wdata (in_key_word),
    .re    (rd_en),
    .raddr (raddr),
    .rdata (rk_lo)
  );

  // Shared round unit
  aes128_round u_round (
    .state_in    (blk_r),
    .round_key   ({rk_hi, rk_lo}),
    .final_round (rnd_r == LAST_RND),
    .state_out   (round_out)
  );

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != ST_IDLE);

  // Sequencer: next state, key reads and output register
  always_comb begin
    state_nxt     = state_r;
    rnd_nxt       = rnd_r;
    blk_nxt       = blk_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    rd_en         = 1'b0;
    raddr         = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_req_type == REQ_ENC)) begin
          blk_nxt   = {in_block_hi, in_block_lo};
          rd_en     = 1'b1;
          raddr     = '0;
          state_nxt = ST_KEY0;
        end
      end
      ST_KEY0: begin
        // initial key addition, fetch round 1 key
        blk_nxt   = blk_r ^ {rk_hi, rk_lo};
        rd_en     = 1'b1;
        raddr     = RA_W'(1);
        rnd_nxt   = RA_W'(1);
        state_nxt = ST_ROUND;
      end
      ST_ROUND: begin
        blk_nxt = round_out;
        if (rnd_r == LAST_RND) begin
          if (out_free) begin
            out_nxt       = round_out;
            out_valid_nxt = 1'b1;
            state_nxt     = ST_IDLE;
          end else begin
            state_nxt = ST_HOLD;
          end
        end else begin
          rd_en   = 1'b1;
          raddr   = rnd_r + RA_W'(1);
          rnd_nxt = rnd_r + RA_W'(1);
        end
      end
      ST_HOLD: begin
        // previous result still waiting downstream
        if (out_free) begin
          out_nxt       = blk_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    rnd_r <= rnd_nxt;
    blk_r <= blk_nxt;
    out_r <= out_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_cipher_hi = out_r[BLOCK_W-1:WORD_W];
  assign out_cipher_lo = out_r[WORD_W-1:0];

endmodule
